FILE: src/autorange_heatmap_colorizer_defines.svh
// assertion helpers used by the checker file
`ifndef AUTORANGE_HEATMAP_COLORIZER_DEFINES_SVH
`define AUTORANGE_HEATMAP_COLORIZER_DEFINES_SVH

// clocked assertion, held off while reset is low
`define AHC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// clocked assertion that is also checked during reset
`define AHC_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

FILE: src/ahc_pkg.sv
// ----------------------------------------------------------------------------
// ahc_pkg
// Types and constants of the autorange heatmap colorizer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package ahc_pkg;

  localparam int unsigned SAMPLE_BITS = 16;
  localparam int unsigned COORD_BITS  = 7;
  localparam int unsigned CHAN_BITS   = 8;
  localparam int unsigned HUE_BITS    = 14;
  localparam int unsigned NUM_BITS    = SAMPLE_BITS + HUE_BITS;
  localparam int unsigned CFG_IDX_BITS = 2;

  // full hue scale is 15360 = 16384 - 1024
  localparam int unsigned HUE_FULL_SHIFT_HI = 14;
  localparam int unsigned HUE_FULL_SHIFT_LO = 10;

  localparam logic [CFG_IDX_BITS-1:0] REG_RANGE_LOW  = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_RANGE_HIGH = 2'd1;

  typedef struct packed {
    logic [COORD_BITS-1:0]         col;
    logic [COORD_BITS-1:0]         row;
    logic signed [SAMPLE_BITS-1:0] sample;
  } ahc_item_t;

  typedef struct packed {
    logic [COORD_BITS-1:0] pixel_col;
    logic [COORD_BITS-1:0] pixel_row;
    logic [CHAN_BITS-1:0]  red;
    logic [CHAN_BITS-1:0]  green;
    logic [CHAN_BITS-1:0]  blue;
  } ahc_pixel_t;

  typedef struct packed {
    logic start;
  } ahc_div_ctrl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } ahc_div_stat_t;

endpackage

`default_nettype wire

FILE: src/ahc_divider.sv
// ----------------------------------------------------------------------------
// ahc_divider
// Restoring divider, one quotient bit per cycle, for the hue scale.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ahc_divider
  import ahc_pkg::*;
(
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire ahc_div_ctrl_t          ctrl_i,
  input  wire logic [NUM_BITS-1:0]    numer_i,
  input  wire logic [SAMPLE_BITS-1:0] denom_i,
  output      ahc_div_stat_t          stat_o,
  output      logic [HUE_BITS-1:0]    quot_o
);

  localparam int unsigned CNT_BITS = $clog2(HUE_BITS + 1);

  logic [SAMPLE_BITS-1:0] rem_q, rem_d;
  logic [SAMPLE_BITS-1:0] den_q, den_d;
  logic [HUE_BITS-1:0]    shf_q, shf_d;
  logic [CNT_BITS-1:0]    cnt_q, cnt_d;
  logic                   busy_q, busy_d;
  logic                   done_q, done_d;
  logic [SAMPLE_BITS+1:0] trial;

  // the numerator top half is already below the divisor
  assign trial = {1'b0, rem_q, shf_q[HUE_BITS-1]} - {2'b00, den_q};

  always_comb begin
    rem_d  = rem_q;
    den_d  = den_q;
    shf_d  = shf_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (ctrl_i.start) begin
      rem_d  = numer_i[NUM_BITS-1:HUE_BITS];
      shf_d  = numer_i[HUE_BITS-1:0];
      den_d  = denom_i;
      cnt_d  = CNT_BITS'(HUE_BITS);
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (trial[SAMPLE_BITS+1]) begin
        rem_d = {rem_q[SAMPLE_BITS-2:0], shf_q[HUE_BITS-1]};
        shf_d = {shf_q[HUE_BITS-2:0], 1'b0};
      end else begin
        rem_d = trial[SAMPLE_BITS-1:0];
        shf_d = {shf_q[HUE_BITS-2:0], 1'b1};
      end
      cnt_d = cnt_q - CNT_BITS'(1);
      if (cnt_q == CNT_BITS'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    den_q <= den_d;
    shf_q <= shf_d;
  end

  assign stat_o.busy = busy_q;
  assign stat_o.done = done_q;
  assign quot_o      = shf_q;

endmodule

`default_nettype wire

FILE: src/ahc_colour.sv
// ----------------------------------------------------------------------------
// ahc_colour
// Maps a hue in 1/64 degree to red, green and blue at full saturation.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ahc_colour
  import ahc_pkg::*;
(
  input  wire logic [HUE_BITS-1:0]  hue_i,
  input  wire logic                 flat_i,
  output      logic [CHAN_BITS-1:0] red_o,
  output      logic [CHAN_BITS-1:0] green_o,
  output      logic [CHAN_BITS-1:0] blue_o
);

  localparam int unsigned FRAC_BITS = 12;
  localparam logic [HUE_BITS-1:0] HUE_SECTOR = 14'd3840;
  localparam logic [CHAN_BITS-1:0] CHAN_FULL = 8'd255;

  localparam logic [2:0] SECT_RED_YEL = 3'd0;
  localparam logic [2:0] SECT_YEL_GRN = 3'd1;
  localparam logic [2:0] SECT_GRN_CYN = 3'd2;
  localparam logic [2:0] SECT_CYN_BLU = 3'd3;
  localparam logic [2:0] SECT_BLU_MAG = 3'd4;

  logic [2:0]           sect;
  logic [HUE_BITS-1:0]  base;
  logic [FRAC_BITS-1:0] frac;
  logic [FRAC_BITS-1:0] ramp_in;
  logic [15:0]          prod;
  logic [CHAN_BITS-1:0] ramp;

  always_comb begin
    if (hue_i >= 4 * HUE_SECTOR) begin
      sect = SECT_BLU_MAG;
      base = HUE_BITS'(4 * HUE_SECTOR);
    end else if (hue_i >= 3 * HUE_SECTOR) begin
      sect = SECT_CYN_BLU;
      base = HUE_BITS'(3 * HUE_SECTOR);
    end else if (hue_i >= 2 * HUE_SECTOR) begin
      sect = SECT_GRN_CYN;
      base = HUE_BITS'(2 * HUE_SECTOR);
    end else if (hue_i >= HUE_SECTOR) begin
      sect = SECT_YEL_GRN;
      base = HUE_SECTOR;
    end else begin
      sect = SECT_RED_YEL;
      base = '0;
    end
  end

  assign frac    = FRAC_BITS'(hue_i - base);
  assign ramp_in = sect[0] ? (FRAC_BITS'(HUE_SECTOR) - frac) : frac;
  // 255/3840 is exactly 17/256
  assign prod    = {4'd0, ramp_in} + {ramp_in, 4'd0};
  assign ramp    = prod[15:8];

  always_comb begin
    red_o   = '0;
    green_o = '0;
    blue_o  = CHAN_FULL;
    if (!flat_i) begin
      case (sect)
        SECT_RED_YEL: begin
          red_o = CHAN_FULL; green_o = ramp; blue_o = '0;
        end
        SECT_YEL_GRN: begin
          red_o = ramp; green_o = CHAN_FULL; blue_o = '0;
        end
        SECT_GRN_CYN: begin
          red_o = '0; green_o = CHAN_FULL; blue_o = ramp;
        end
        SECT_CYN_BLU: begin
          red_o = '0; green_o = ramp; blue_o = CHAN_FULL;
        end
        default: begin
          red_o = ramp; green_o = '0; blue_o = CHAN_FULL;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

FILE: src/autorange_heatmap_colorizer.sv
// Each request passes widen, scale, the 14 steps of the single restoring divider,
// its done flag and colour before the block returns to idle and takes the next one.
// A waiting result holds the colour step, so it delays the result behind it.
// Reset (asynchronous, active low) clears the running range to 0..0 and
// empties the output register; no clearing pass is needed.
// ----------------------------------------------------------------------------
// autorange_heatmap_colorizer
// Widens a running min/max per sample and maps the sample to a blue-to-red hue.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module autorange_heatmap_colorizer
  import ahc_pkg::*;
#(
  parameter int unsigned GRID_SIZE = 128
) (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire logic                    in_valid_i,
  output      logic                    in_ready_o,
  input  wire ahc_item_t               in_data_i,
  output      logic                    out_valid_o,
  input  wire logic                    out_ready_i,
  output      ahc_pixel_t              out_data_o,
  input  wire logic                    cfg_valid_i,
  output      logic                    cfg_ready_o,
  input  wire logic [CFG_IDX_BITS-1:0] cfg_index_i,
  input  wire logic [SAMPLE_BITS-1:0]  cfg_data_i
);

  typedef enum logic [4:0] {
    ST_IDLE   = 5'b00001,
    ST_WIDEN  = 5'b00010,
    ST_SCALE  = 5'b00100,
    ST_DIVIDE = 5'b01000,
    ST_COLOUR = 5'b10000
  } state_e;

  localparam int unsigned COORD_SPAN = 1 << COORD_BITS;

  // coordinate wrap by restoring subtraction of shifted grid sizes
  function automatic logic [COORD_BITS-1:0] wrap_coord(input logic [COORD_BITS-1:0] v);
    logic [COORD_BITS-1:0] r;
    int unsigned           k;
    r = v;
    if (GRID_SIZE < COORD_SPAN) begin
      for (k = COORD_BITS; k > 0; k--) begin
        if (32'(r) >= (32'(GRID_SIZE) << (k - 1))) begin
          r = r - COORD_BITS'(32'(GRID_SIZE) << (k - 1));
        end
      end
    end
    return r;
  endfunction

  state_e state_q, state_d;

  logic signed [SAMPLE_BITS-1:0] min_q, min_d;
  logic signed [SAMPLE_BITS-1:0] max_q, max_d;
  ahc_item_t                     item_q, item_d;
  logic                          flat_q, flat_d;
  logic                          out_valid_q, out_valid_d;
  ahc_pixel_t                    out_q, out_d;

  ahc_div_ctrl_t          div_ctrl;
  ahc_div_stat_t          div_stat;
  logic [HUE_BITS-1:0]    hue;
  logic [SAMPLE_BITS:0]   span_w;
  logic [SAMPLE_BITS:0]   diff_w;
  logic [NUM_BITS-1:0]    numer;
  logic [CHAN_BITS-1:0]   red, green, blue;
  logic                   in_fire, cfg_fire, out_free;

  assign in_ready_o  = (state_q == ST_IDLE);
  assign cfg_ready_o = 1'b1;
  assign in_fire     = in_valid_i && in_ready_o;
  assign cfg_fire    = cfg_valid_i && cfg_ready_o;
  assign out_free    = !out_valid_q || out_ready_i;

  // both differences are non-negative once the range holds the sample
  assign span_w = {max_q[SAMPLE_BITS-1], max_q} - {min_q[SAMPLE_BITS-1], min_q};
  assign diff_w = {max_q[SAMPLE_BITS-1], max_q}
                - {item_q.sample[SAMPLE_BITS-1], item_q.sample};
  assign numer  = (NUM_BITS'(diff_w[SAMPLE_BITS-1:0]) << HUE_FULL_SHIFT_HI)
                - (NUM_BITS'(diff_w[SAMPLE_BITS-1:0]) << HUE_FULL_SHIFT_LO);

  assign div_ctrl.start = (state_q == ST_SCALE);

  ahc_divider i_divider (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctrl_i  (div_ctrl),
    .numer_i (numer),
    .denom_i (span_w[SAMPLE_BITS-1:0]),
    .stat_o  (div_stat),
    .quot_o  (hue)
  );

  ahc_colour i_colour (
    .hue_i   (hue),
    .flat_i  (flat_q),
    .red_o   (red),
    .green_o (green),
    .blue_o  (blue)
  );

  always_comb begin
    state_d     = state_q;
    min_d       = min_q;
    max_d       = max_q;
    item_d      = item_q;
    flat_d      = flat_q;
    out_valid_d = out_valid_q;
    out_d       = out_q;

    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          item_d.col    = wrap_coord(in_data_i.col);
          item_d.row    = wrap_coord(in_data_i.row);
          item_d.sample = in_data_i.sample;
          state_d       = ST_WIDEN;
        end
      end
      ST_WIDEN: begin
        if (item_q.sample < min_q) begin
          min_d = item_q.sample;
        end
        if (item_q.sample > max_q) begin
          max_d = item_q.sample;
        end
        state_d = ST_SCALE;
      end
      ST_SCALE: begin
        flat_d  = (max_q == min_q);
        state_d = ST_DIVIDE;
      end
      ST_DIVIDE: begin
        if (div_stat.done) begin
          state_d = ST_COLOUR;
        end
      end
      ST_COLOUR: begin
        if (out_free) begin
          out_d.pixel_col = item_q.col;
          out_d.pixel_row = item_q.row;
          out_d.red       = red;
          out_d.green     = green;
          out_d.blue      = blue;
          out_valid_d     = 1'b1;
          state_d         = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase

    // range writes reload the running extremes
    if (cfg_fire) begin
      case (cfg_index_i)
        REG_RANGE_LOW:  min_d = cfg_data_i;
        REG_RANGE_HIGH: max_d = cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      min_q       <= '0;
      max_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      min_q       <= min_d;
      max_q       <= max_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    item_q <= item_d;
    flat_q <= flat_d;
    out_q  <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

`default_nettype wire

FILE: src/ahc_checker.sv
// ----------------------------------------------------------------------------
// ahc_checker
// Port-level checks on the autorange heatmap colorizer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "autorange_heatmap_colorizer_defines.svh"

module ahc_checker
  import ahc_pkg::*;
(
  input wire logic                    clk_i,
  input wire logic                    rst_ni,
  input wire logic                    in_valid_i,
  input wire logic                    in_ready_o,
  input wire ahc_item_t               in_data_i,
  input wire logic                    out_valid_o,
  input wire logic                    out_ready_i,
  input wire ahc_pixel_t              out_data_o,
  input wire logic                    cfg_valid_i,
  input wire logic                    cfg_ready_o,
  input wire logic [CFG_IDX_BITS-1:0] cfg_index_i,
  input wire logic [SAMPLE_BITS-1:0]  cfg_data_i
);

  logic in_fire;
  logic out_stall;
  logic chan_has_full, chan_has_zero;

  assign in_fire   = in_valid_i && in_ready_o;
  assign out_stall = out_valid_o && !out_ready_i;

  // a fully saturated colour has one channel at full and one at zero
  assign chan_has_full = (out_data_o.red == 8'd255) || (out_data_o.green == 8'd255)
                      || (out_data_o.blue == 8'd255);
  assign chan_has_zero = (out_data_o.red == 8'd0) || (out_data_o.green == 8'd0)
                      || (out_data_o.blue == 8'd0);

  `AHC_ASSERT(a_busy_after_req, in_fire |=> !in_ready_o, "request taken while busy")
  `AHC_ASSERT(a_no_instant_result, in_fire |=> !$rose(out_valid_o), "result too early")
  `AHC_ASSERT(a_out_hold, out_stall |=> out_valid_o && $stable(out_data_o), "result lost")
  `AHC_ASSERT(a_saturated, out_valid_o |-> chan_has_full && chan_has_zero, "not saturated")

endmodule

bind autorange_heatmap_colorizer ahc_checker i_ahc_checker (.*);

`default_nettype wire
